// ===== hdl/dft8_pkg.sv =====
// ----------------------------------------------------------------------------
// dft8_pkg
// Shared types, constants and twiddle tables for the 8-point forward DFT.
// ----------------------------------------------------------------------------
package dft8_pkg;

    // transform size and fixed field widths
    localparam int DFT_POINTS = 8;
    localparam int IDX_BITS   = 3;
    localparam int BIN_BITS   = 21;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    // accumulator headroom over the sample width
    localparam int ACC_GUARD_BITS = 5;

    // sqrt(1/2) scaled by 2^64
    localparam logic [63:0] HALF_ROOT2_Q64 = 64'hB504F333F9DE6484;

    // twiddle part selector
    typedef enum logic [2:0] {
        COEF_ZERO,
        COEF_POS_ONE,
        COEF_NEG_ONE,
        COEF_POS_H,
        COEF_NEG_H
    } t_coef;

    // real part of W^m, indexed by m
    localparam t_coef COS_SEL [DFT_POINTS] = '{
        COEF_POS_ONE, COEF_POS_H, COEF_ZERO, COEF_NEG_H,
        COEF_NEG_ONE, COEF_NEG_H, COEF_ZERO, COEF_POS_H
    };

    // imaginary part of W^m (minus sine), indexed by m
    localparam t_coef NSIN_SEL [DFT_POINTS] = '{
        COEF_ZERO, COEF_NEG_H, COEF_NEG_ONE, COEF_NEG_H,
        COEF_ZERO, COEF_POS_H, COEF_POS_ONE, COEF_POS_H
    };

    // sqrt(1/2) rounded to frac fractional bits
    function automatic logic [31:0] half_root2(input int frac);
        logic [63:0] q;
        q = (HALF_ROOT2_Q64 >> (63 - frac)) + 64'd1;
        return 32'(q >> 1);
    endfunction

endpackage

// ===== hdl/dft8_forward.sv =====
// ----------------------------------------------------------------------------
// dft8_forward
// Streaming forward 8-point DFT: one complex sample per beat, eight bins out
// after every eighth sample.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  sample   in         i_valid / o_stall  i_sample_re, i_sample_im
//  bin      out        o_valid / i_stall  o_bin_index, o_bin_re, o_bin_im, o_bin_last
//
//  one sample is taken every cycle while o_stall is low; the sqrt(1/2)
//  products are formed on the way into the sample register, and the eight
//  twiddle MACs run between that register and the accumulators.
//  the eighth sample of a frame moves the sums into an output bank that sends
//  bins 0..7 one per cycle while i_stall is low, as the next frame accumulates.
//  o_stall rises only when a frame completes while the bank is still full.
//  reset (synchronous, active low) clears accumulators, counter and valids.
// ----------------------------------------------------------------------------
module dft8_forward
    import dft8_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [IDX_BITS-1:0]           o_bin_index,
    output logic signed [BIN_BITS-1:0]    o_bin_re,
    output logic signed [BIN_BITS-1:0]    o_bin_im,
    output logic                          o_bin_last
);

    localparam int PH       = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int RW       = SAMPLE_BITS + 2;
    localparam int ACC_BITS = SAMPLE_BITS + ACC_GUARD_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DFT_POINTS - 1);
    localparam logic signed [COEF_FRAC_BITS:0] HALF_S =
        (COEF_FRAC_BITS+1)'(half_root2(COEF_FRAC_BITS));

    // sample register
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_xr;
    logic signed [SAMPLE_BITS-1:0] r_xi;
    logic signed [PH-1:0]          r_xr_h;
    logic signed [PH-1:0]          r_xi_h;
    logic signed [PH:0]            w_xr_h;
    logic signed [PH:0]            w_xi_h;

    // accumulators and frame counter
    logic [IDX_BITS-1:0]        r_cnt;
    logic signed [ACC_BITS-1:0] r_acc_re [DFT_POINTS];
    logic signed [ACC_BITS-1:0] r_acc_im [DFT_POINTS];
    logic signed [ACC_BITS-1:0] n_acc_re [DFT_POINTS];
    logic signed [ACC_BITS-1:0] n_acc_im [DFT_POINTS];
    logic signed [RW-1:0]       w_prod_re [DFT_POINTS];
    logic signed [RW-1:0]       w_prod_im [DFT_POINTS];

    // output bank
    logic                       r_bank_busy;
    logic [IDX_BITS-1:0]        r_idx;
    logic signed [ACC_BITS-1:0] r_bank_re [DFT_POINTS];
    logic signed [ACC_BITS-1:0] r_bank_im [DFT_POINTS];
    logic [ACC_BITS+BIN_BITS-1:0] w_ext_re;
    logic [ACC_BITS+BIN_BITS-1:0] w_ext_im;

    logic out_take;
    logic bank_free;
    logic adv;
    logic frame_end;

    // handshake control
    assign out_take  = r_bank_busy && !i_stall;
    assign bank_free = !r_bank_busy || (out_take && (r_idx == LAST_IDX));
    assign adv       = r_in_valid && ((r_cnt != LAST_IDX) || bank_free);
    assign frame_end = adv && (r_cnt == LAST_IDX);
    assign o_stall   = r_in_valid && !adv;

    // sqrt(1/2) products ahead of the sample register
    assign w_xr_h = i_sample_re * HALF_S;
    assign w_xi_h = i_sample_im * HALF_S;

    // sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_xr   <= i_sample_re;
            r_xi   <= i_sample_im;
            r_xr_h <= w_xr_h[PH-1:0];
            r_xi_h <= w_xi_h[PH-1:0];
        end
    end

    // twiddle products
    dft8_twiddle_mul #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .i_n       (r_cnt),
        .i_xr      (r_xr),
        .i_xi      (r_xi),
        .i_xr_h    (r_xr_h),
        .i_xi_h    (r_xi_h),
        .o_prod_re (w_prod_re),
        .o_prod_im (w_prod_im)
    );

    // accumulate sums
    always_comb begin
        for (int k = 0; k < DFT_POINTS; k++) begin
            n_acc_re[k] = r_acc_re[k] + ACC_BITS'(w_prod_re[k]);
            n_acc_im[k] = r_acc_im[k] + ACC_BITS'(w_prod_im[k]);
        end
    end

    // accumulators, cleared when a frame closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int k = 0; k < DFT_POINTS; k++) begin
                r_acc_re[k] <= '0;
                r_acc_im[k] <= '0;
            end
        end else if (adv) begin
            r_cnt <= r_cnt + 1'b1;
            for (int k = 0; k < DFT_POINTS; k++) begin
                r_acc_re[k] <= frame_end ? '0 : n_acc_re[k];
                r_acc_im[k] <= frame_end ? '0 : n_acc_im[k];
            end
        end
    end

    // output bank control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_busy <= 1'b0;
            r_idx       <= '0;
        end else if (frame_end) begin
            r_bank_busy <= 1'b1;
            r_idx       <= '0;
        end else if (out_take) begin
            r_bank_busy <= (r_idx != LAST_IDX);
            r_idx       <= r_idx + 1'b1;
        end
    end

    // output bank data
    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            for (int k = 0; k < DFT_POINTS; k++) begin
                r_bank_re[k] <= n_acc_re[k];
                r_bank_im[k] <= n_acc_im[k];
            end
        end
    end

    // bin beat: low bits of the accumulator, zero-filled when narrower
    assign w_ext_re = {BIN_BITS'(0), r_bank_re[r_idx]};
    assign w_ext_im = {BIN_BITS'(0), r_bank_im[r_idx]};

    assign o_valid     = r_bank_busy;
    assign o_bin_index = r_idx;
    assign o_bin_re    = w_ext_re[BIN_BITS-1:0];
    assign o_bin_im    = w_ext_im[BIN_BITS-1:0];
    assign o_bin_last  = (r_idx == LAST_IDX);

endmodule

// ===== hdl/dft8_twiddle_mul.sv =====
// ----------------------------------------------------------------------------
// dft8_twiddle_mul
// Multiplies one registered sample by the eight twiddles W^(n*k) and rounds
// each complex product back to the sample scale (round half up).
// ----------------------------------------------------------------------------
module dft8_twiddle_mul
    import dft8_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic [IDX_BITS-1:0]                          i_n,
    input  logic signed [SAMPLE_BITS-1:0]                i_xr,
    input  logic signed [SAMPLE_BITS-1:0]                i_xi,
    input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_xr_h,
    input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_xi_h,
    output logic signed [SAMPLE_BITS+1:0]                o_prod_re [DFT_POINTS],
    output logic signed [SAMPLE_BITS+1:0]                o_prod_im [DFT_POINTS]
);

    localparam int PH = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int PW = SAMPLE_BITS + COEF_FRAC_BITS + 2;
    localparam int RW = SAMPLE_BITS + 2;
    localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (COEF_FRAC_BITS - 1);

    // one real term: sample times 0, +-1 or +-sqrt(1/2)
    function automatic logic signed [PW-1:0] term(
        input t_coef                  sel,
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic signed [PH-1:0]   xh
    );
        logic signed [PW-1:0] x_one;
        logic signed [PW-1:0] x_h;
        x_one = PW'(x) <<< COEF_FRAC_BITS;
        x_h   = PW'(xh);
        case (sel)
            COEF_POS_ONE: term = x_one;
            COEF_NEG_ONE: term = -x_one;
            COEF_POS_H:   term = x_h;
            COEF_NEG_H:   term = -x_h;
            default:      term = '0;
        endcase
    endfunction

    // round half up, dropping the COEF_FRAC_BITS fractional bits
    function automatic logic signed [RW-1:0] round_prod(input logic signed [PW-1:0] v);
        logic signed [PW:0] t;
        t = (PW+1)'(v) + RND;
        t = t >>> COEF_FRAC_BITS;
        return t[RW-1:0];
    endfunction

    // eight complex products, one per bin
    always_comb begin : b_prod
        logic [IDX_BITS-1:0]  m;
        t_coef                cs;
        t_coef                ns;
        logic signed [PW-1:0] v_re;
        logic signed [PW-1:0] v_im;
        for (int k = 0; k < DFT_POINTS; k++) begin
            m    = IDX_BITS'(i_n * IDX_BITS'(k));
            cs   = COS_SEL[m];
            ns   = NSIN_SEL[m];
            v_re = term(cs, i_xr, i_xr_h) - term(ns, i_xi, i_xi_h);
            v_im = term(ns, i_xr, i_xr_h) + term(cs, i_xi, i_xi_h);
            o_prod_re[k] = round_prod(v_re);
            o_prod_im[k] = round_prod(v_im);
        end
    end

endmodule

// ===== hdl/dft8_checker.sv =====
// ----------------------------------------------------------------------------
// dft8_checker
// Port-level checks on the bin output of the 8-point DFT.
// ----------------------------------------------------------------------------
module dft8_checker
    import dft8_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [IDX_BITS-1:0]        o_bin_index,
    input logic signed [BIN_BITS-1:0] o_bin_re,
    input logic signed [BIN_BITS-1:0] o_bin_im,
    input logic                       o_bin_last
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DFT_POINTS - 1);

    // stalled bin beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bin_index)
            && $stable(o_bin_re) && $stable(o_bin_im))
        else $error("stalled bin beat changed");

    // a frame opens on bin zero
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_bin_index == '0)
        else $error("frame did not start at bin zero");

    // bins of a frame follow back to back in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_bin_last |=>
            o_valid && (o_bin_index == $past(o_bin_index) + 1'b1))
        else $error("bin sequence broken");

    // last marker sits on bin seven only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bin_last == (o_bin_index == LAST_IDX)))
        else $error("last marker on wrong bin");

endmodule

bind dft8_forward dft8_checker u_dft8_checker (.*);

// ===== verif/dft8_forward_test.sv =====
// ----------------------------------------------------------------------------
// dft8_forward_test
// Self-checking bench for the streaming 8-point forward DFT. A short table of
// directed frames (impulse and full-scale DC with hand-worked bins, then mixed
// extremes) is followed by random frames. Every accepted sample beat feeds a
// bit-true fixed-point model of the transform, and every bin beat is compared
// in order against the bins that model expects. Both sides idle at random,
// and the bin side holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module dft8_forward_test;
    import dft8_pkg::*;

    localparam int SMP_BITS      = SAMPLE_BITS_DEF;
    localparam int FRAC_BITS     = COEF_FRAC_BITS_DEF;
    localparam longint COEF_ONE  = 64'sd1 << FRAC_BITS;
    localparam longint COEF_H    = 64'sd23170;
    localparam longint ROUND_ADD = 64'sd1 << (FRAC_BITS - 1);

    localparam int DIR_LEN       = 24;
    localparam int TOTAL_SAMPLES = DIR_LEN + 296;
    localparam int PRESSURE_AT   = 240;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    // one directed sample beat, with the bin it lines up with where known
    typedef struct packed {
        logic signed [SMP_BITS-1:0] re;
        logic signed [SMP_BITS-1:0] im;
        logic                       typed;
        logic signed [BIN_BITS-1:0] bin_re;
        logic signed [BIN_BITS-1:0] bin_im;
    } t_stim_row;

    typedef struct {
        logic [IDX_BITS-1:0]        idx;
        logic signed [BIN_BITS-1:0] re;
        logic signed [BIN_BITS-1:0] im;
        logic                       last;
    } t_bin;

    // impulse, full-scale negative dc, then assorted extremes
    localparam t_stim_row STIM_TABLE [DIR_LEN] = '{
        '{16'sh7FFF, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh0000, 16'sh0000, 1'b1, 21'sd32767, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, -21'sd262144, -21'sd262144},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b1, 21'sd0, 21'sd0},
        '{16'sh7FFF, 16'sh8000, 1'b0, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh7FFF, 1'b0, 21'sd0, 21'sd0},
        '{16'sh0000, 16'shFFFF, 1'b0, 21'sd0, 21'sd0},
        '{16'shFFFF, 16'sh0000, 1'b0, 21'sd0, 21'sd0},
        '{16'sh0001, 16'sh0001, 1'b0, 21'sd0, 21'sd0},
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 21'sd0, 21'sd0},
        '{16'sh8000, 16'sh8000, 1'b0, 21'sd0, 21'sd0},
        '{16'sh5555, 16'shAAAA, 1'b0, 21'sd0, 21'sd0}
    };

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic signed [SMP_BITS-1:0] i_sample_re = '0;
    logic signed [SMP_BITS-1:0] i_sample_im = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [IDX_BITS-1:0]        o_bin_index;
    logic signed [BIN_BITS-1:0] o_bin_re;
    logic signed [BIN_BITS-1:0] o_bin_im;
    logic                       o_bin_last;

    // model state: running bin sums and position in the frame
    logic signed [BIN_BITS-1:0] sum_re [DFT_POINTS];
    logic signed [BIN_BITS-1:0] sum_im [DFT_POINTS];
    logic [IDX_BITS-1:0]        frame_pos = '0;
    t_bin                       bin_expect_q [$];

    int samples_loaded = 0;
    int samples_in     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int fail_count     = 0;
    int cycle_count    = 0;

    dft8_forward dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bin_index (o_bin_index),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_bin_last  (o_bin_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < DFT_POINTS; k++) begin
            sum_re[k] = '0;
            sum_im[k] = '0;
        end
    end

    // twiddle part as a scaled integer
    function automatic longint coef_level(input t_coef sel);
        case (sel)
            COEF_POS_ONE: return COEF_ONE;
            COEF_NEG_ONE: return -COEF_ONE;
            COEF_POS_H:   return COEF_H;
            COEF_NEG_H:   return -COEF_H;
            default:      return 64'sd0;
        endcase
    endfunction

    // add one sample into every bin; on the eighth, queue the eight bins
    function automatic void dft_accumulate(input logic signed [SMP_BITS-1:0] xr_in,
                                           input logic signed [SMP_BITS-1:0] xi_in,
                                           input int seq);
        longint xr;
        longint xi;
        longint cr;
        longint ci;
        longint pr;
        longint pi;
        int     m;
        int     row;
        t_bin   b;
        xr = xr_in;
        xi = xi_in;
        for (int k = 0; k < DFT_POINTS; k++) begin
            m  = (int'(frame_pos) * k) % DFT_POINTS;
            cr = coef_level(COS_SEL[m]);
            ci = coef_level(NSIN_SEL[m]);
            pr = (xr * cr - xi * ci + ROUND_ADD) >>> FRAC_BITS;
            pi = (xr * ci + xi * cr + ROUND_ADD) >>> FRAC_BITS;
            sum_re[k] = sum_re[k] + pr[BIN_BITS-1:0];
            sum_im[k] = sum_im[k] + pi[BIN_BITS-1:0];
        end
        if (frame_pos == IDX_BITS'(DFT_POINTS - 1)) begin
            for (int k = 0; k < DFT_POINTS; k++) begin
                row    = seq - (DFT_POINTS - 1) + k;
                b.idx  = IDX_BITS'(k);
                b.re   = sum_re[k];
                b.im   = sum_im[k];
                b.last = (k == DFT_POINTS - 1);
                // hand-worked bins of the directed frames take precedence
                if (row < DIR_LEN && STIM_TABLE[row].typed) begin
                    b.re = STIM_TABLE[row].bin_re;
                    b.im = STIM_TABLE[row].bin_im;
                end
                bin_expect_q.push_back(b);
                sum_re[k] = '0;
                sum_im[k] = '0;
            end
        end
        frame_pos = frame_pos + 1'b1;
    endfunction

    // random sample part, weighted towards the rails and tiny values
    function automatic logic signed [SMP_BITS-1:0] rand_part();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SMP_BITS'($urandom_range(0, 7)) - 16'sd4;
            default: return SMP_BITS'($urandom);
        endcase
    endfunction

    // idle rates: sender-light then receiver-light, then none
    function automatic int send_idle_pct();
        if (samples_in < 120) return 24;
        if (samples_in < 220) return 50;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (samples_in < 120) return 50;
        if (samples_in < 220) return 24;
        return 0;
    endfunction

    // sample sender: hold a stalled beat, otherwise load the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (samples_loaded < TOTAL_SAMPLES &&
                (hold_left != 0 || $urandom_range(0, 99) >= send_idle_pct())) begin
                if (samples_loaded < DIR_LEN) begin
                    i_sample_re <= STIM_TABLE[samples_loaded].re;
                    i_sample_im <= STIM_TABLE[samples_loaded].im;
                end else begin
                    i_sample_re <= rand_part();
                    i_sample_im <= rand_part();
                end
                i_valid        <= 1'b1;
                samples_loaded <= samples_loaded + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // bin receiver: random stall, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && samples_in >= PRESSURE_AT) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct());
        end
    end

    // sample beats into the model
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            dft_accumulate(i_sample_re, i_sample_im, samples_in);
            samples_in <= samples_in + 1;
        end
    end

    // bin beats against the oldest expected bin
    always @(posedge i_clk) begin
        t_bin e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (bin_expect_q.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < REPORT_MAX)
                    $display("unexpected bin beat: index %0d re %0d im %0d last %0b",
                             o_bin_index, o_bin_re, o_bin_im, o_bin_last);
            end else begin
                e = bin_expect_q.pop_front();
                if (o_bin_index !== e.idx || o_bin_re !== e.re ||
                    o_bin_im !== e.im || o_bin_last !== e.last) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < REPORT_MAX)
                        $display("bin mismatch: exp idx %0d re %0d im %0d last %0b, %s %0d %0d %0d %0b",
                                 e.idx, e.re, e.im, e.last, "got",
                                 o_bin_index, o_bin_re, o_bin_im, o_bin_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dft8_forward_test failed");
            $finish;
        end
    end

    // reset, then wait for all samples taken and all bins seen
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (samples_in < TOTAL_SAMPLES) @(posedge i_clk);
        while (bin_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && bin_expect_q.size() == 0) begin
            $display("dft8_forward_test passed");
        end else begin
            $display("dft8_forward_test failed");
        end
        $finish;
    end

endmodule
